// ===== hw/rtl/jvm_pkg.sv =====
// shared types, opcodes and constants for the integer bytecode execute unit
`timescale 1ns / 1ps
package jvm_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int LOCAL_COUNT = 256;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int LV_W = $clog2(LOCAL_COUNT);

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_RET   = 3'd1;
	localparam logic [2:0] ST_END   = 3'd2;
	localparam logic [2:0] ST_UNSUP = 3'd3;
	localparam logic [2:0] ST_DIV0  = 3'd4;
	localparam logic [2:0] ST_UNDER = 3'd5;
	localparam logic [2:0] ST_OVER  = 3'd6;

	localparam logic [7:0] OP_ICONST_M1 = 8'h02;
	localparam logic [7:0] OP_ICONST_5  = 8'h08;
	localparam logic [7:0] OP_BIPUSH    = 8'h10;
	localparam logic [7:0] OP_SIPUSH    = 8'h11;
	localparam logic [7:0] OP_ILOAD_0   = 8'h1A;
	localparam logic [7:0] OP_ILOAD_3   = 8'h1D;
	localparam logic [7:0] OP_ISTORE_0  = 8'h3B;
	localparam logic [7:0] OP_ISTORE_3  = 8'h3E;
	localparam logic [7:0] OP_POP       = 8'h57;
	localparam logic [7:0] OP_DUP       = 8'h59;
	localparam logic [7:0] OP_IADD      = 8'h60;
	localparam logic [7:0] OP_ISUB      = 8'h64;
	localparam logic [7:0] OP_IMUL      = 8'h68;
	localparam logic [7:0] OP_IDIV      = 8'h6C;
	localparam logic [7:0] OP_IREM      = 8'h70;
	localparam logic [7:0] OP_INEG      = 8'h74;
	localparam logic [7:0] OP_IINC      = 8'h84;
	localparam logic [7:0] OP_IFEQ      = 8'h99;
	localparam logic [7:0] OP_IFLE      = 8'h9E;
	localparam logic [7:0] OP_ICMPEQ    = 8'h9F;
	localparam logic [7:0] OP_ICMPLE    = 8'hA4;
	localparam logic [7:0] OP_GOTO      = 8'hA7;
	localparam logic [7:0] OP_IRETURN   = 8'hAC;
	localparam logic [7:0] OP_RETURN    = 8'hB1;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture the word
		logic rd_b;     // read both stack operands and the local
		logic check;    // evaluate halting conditions
		logic div_start;
		logic commit;   // write stack / locals, produce result
	} jvm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic halt;     // check found a halting case
		logic is_div;
		logic div_done;
	} jvm_sts_t;
endpackage

// ===== hw/rtl/jvm_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle
`timescale 1ns / 1ps
module jvm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quot,
	output logic [31:0] rem
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q, nq_q, nr_q;
	logic [32:0] trial;
	logic [31:0] shl;

	assign shl   = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shl} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			dvs_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			nq_q  <= dividend[31] ^ divisor[31];
			nr_q  <= dividend[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shl;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q ? (32'd0 - quo_q) : quo_q;
	assign rem  = nr_q ? (32'd0 - rem_q) : rem_q;
endmodule

// ===== hw/rtl/jvm_dp.sv =====
// datapath: operand stack, locals, alu, branch and status logic
`timescale 1ns / 1ps
module jvm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jvm_pkg::jvm_cmd_t    cmd,
	output jvm_pkg::jvm_sts_t    sts,
	input  logic [7:0]           func,
	input  logic [7:0]           operand_hi,
	input  logic [7:0]           operand_lo,
	input  logic [15:0]          insn_pc,
	input  logic [15:0]          code_len,
	output logic [15:0]          next_pc,
	output logic                 branch_taken,
	output logic [2:0]           status,
	output logic signed [31:0]   top_value,
	output logic [6:0]           stack_depth
);
	logic [31:0] stk_mem [jvm_pkg::STACK_DEPTH];
	logic [31:0] lv_mem  [jvm_pkg::LOCAL_COUNT];

	logic [7:0]  op_q, hi_q, lo_q;
	logic [15:0] pc_q;
	logic [jvm_pkg::SP_W-1:0] sp_q;
	logic        halted_q;
	logic [2:0]  hcode_q;
	logic [31:0] b_q, a_q, lv_q, top_q, mul_q, nt_q;
	logic [2:0]  chk_q;

	logic [1:0]  npop, npush;
	logic [1:0]  ilen;
	logic        known;
	logic [jvm_pkg::SA_W-1:0] ra_b, ra_a;
	logic [jvm_pkg::LV_W-1:0] lv_idx;
	logic        lv_rd, lv_wr;
	logic [31:0] lv_wdata;
	logic [jvm_pkg::SP_W:0] sp_after;
	logic [2:0]  chk;
	logic [31:0] dq, dr;
	logic        dv_done;
	logic [31:0] res, cmp_a, cmp_b;
	logic        cond, is_br, push_w;
	logic [jvm_pkg::SP_W-1:0] wr_sp, sp_new;
	logic [jvm_pkg::SA_W-1:0] wr_idx;
	logic [15:0] off;

	// decode stack effects
	always_comb begin
		npop = 2'd0; npush = 2'd0; ilen = 2'd1; known = 1'b1;
		if (op_q >= jvm_pkg::OP_ICONST_M1 && op_q <= jvm_pkg::OP_ICONST_5) npush = 2'd1;
		else if (op_q >= jvm_pkg::OP_ILOAD_0 && op_q <= jvm_pkg::OP_ILOAD_3) npush = 2'd1;
		else if (op_q >= jvm_pkg::OP_ISTORE_0 && op_q <= jvm_pkg::OP_ISTORE_3) npop = 2'd1;
		else if (op_q >= jvm_pkg::OP_IFEQ && op_q <= jvm_pkg::OP_IFLE) begin
			npop = 2'd1; ilen = 2'd3;
		end else if (op_q >= jvm_pkg::OP_ICMPEQ && op_q <= jvm_pkg::OP_ICMPLE) begin
			npop = 2'd2; ilen = 2'd3;
		end else if (op_q >= jvm_pkg::OP_IRETURN && op_q <= jvm_pkg::OP_RETURN) known = 1'b1;
		else begin
			case (op_q)
				jvm_pkg::OP_BIPUSH: begin npush = 2'd1; ilen = 2'd2; end
				jvm_pkg::OP_SIPUSH: begin npush = 2'd1; ilen = 2'd3; end
				jvm_pkg::OP_IINC: ilen = 2'd3;
				jvm_pkg::OP_IADD, jvm_pkg::OP_ISUB, jvm_pkg::OP_IMUL,
				jvm_pkg::OP_IDIV, jvm_pkg::OP_IREM: begin npop = 2'd2; npush = 2'd1; end
				jvm_pkg::OP_INEG: begin npop = 2'd1; npush = 2'd1; end
				jvm_pkg::OP_POP: npop = 2'd1;
				jvm_pkg::OP_DUP: begin npop = 2'd1; npush = 2'd2; end
				jvm_pkg::OP_GOTO: ilen = 2'd3;
				default: known = 1'b0;
			endcase
		end
	end

	assign ra_b = jvm_pkg::SA_W'(sp_q - jvm_pkg::SP_W'(1));
	assign ra_a = jvm_pkg::SA_W'(sp_q - jvm_pkg::SP_W'(2));
	assign sp_after = {1'b0, sp_q} - (jvm_pkg::SP_W+1)'(npop) + (jvm_pkg::SP_W+1)'(npush);

	// local index: iload/istore use fixed slots, iinc uses the operand byte
	always_comb begin
		if (op_q >= jvm_pkg::OP_ILOAD_0 && op_q <= jvm_pkg::OP_ILOAD_3)
			lv_idx = jvm_pkg::LV_W'(op_q - jvm_pkg::OP_ILOAD_0);
		else if (op_q >= jvm_pkg::OP_ISTORE_0 && op_q <= jvm_pkg::OP_ISTORE_3)
			lv_idx = jvm_pkg::LV_W'(op_q - jvm_pkg::OP_ISTORE_0);
		else
			lv_idx = jvm_pkg::LV_W'(hi_q);
	end

	always_comb begin
		if (halted_q) chk = hcode_q;
		else if (pc_q >= code_len) chk = jvm_pkg::ST_END;
		else if (!known) chk = jvm_pkg::ST_UNSUP;
		else if (op_q >= jvm_pkg::OP_IRETURN && op_q <= jvm_pkg::OP_RETURN) chk = jvm_pkg::ST_RET;
		else if ({5'd0, npop} > 7'(sp_q)) chk = jvm_pkg::ST_UNDER;
		else if (sp_after > (jvm_pkg::SP_W+1)'(jvm_pkg::STACK_DEPTH)) chk = jvm_pkg::ST_OVER;
		else if ((op_q == jvm_pkg::OP_IDIV || op_q == jvm_pkg::OP_IREM) && b_q == 32'd0)
			chk = jvm_pkg::ST_DIV0;
		else chk = jvm_pkg::ST_OK;
	end

	jvm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(a_q), .divisor(b_q), .done(dv_done), .quot(dq), .rem(dr)
	);

	assign sts.halt     = (chk_q != jvm_pkg::ST_OK);
	assign sts.is_div   = (op_q == jvm_pkg::OP_IDIV || op_q == jvm_pkg::OP_IREM);
	assign sts.div_done = dv_done;

	// result and branch evaluation
	assign cmp_a = (op_q <= jvm_pkg::OP_IFLE) ? b_q : a_q;
	assign cmp_b = (op_q <= jvm_pkg::OP_IFLE) ? 32'd0 : b_q;
	assign off   = {hi_q, lo_q};
	always_comb begin
		case ((op_q <= jvm_pkg::OP_IFLE) ? (op_q - jvm_pkg::OP_IFEQ)
		                                 : (op_q - jvm_pkg::OP_ICMPEQ))
			8'd0: cond = (cmp_a == cmp_b);
			8'd1: cond = (cmp_a != cmp_b);
			8'd2: cond = ($signed(cmp_a) < $signed(cmp_b));
			8'd3: cond = !($signed(cmp_a) < $signed(cmp_b));
			8'd4: cond = ($signed(cmp_b) < $signed(cmp_a));
			default: cond = !($signed(cmp_b) < $signed(cmp_a));
		endcase
	end
	assign is_br = (op_q >= jvm_pkg::OP_IFEQ && op_q <= jvm_pkg::OP_ICMPLE && cond)
		|| op_q == jvm_pkg::OP_GOTO;

	always_comb begin
		push_w = 1'b1;
		res    = 32'd0;
		if (op_q >= jvm_pkg::OP_ICONST_M1 && op_q <= jvm_pkg::OP_ICONST_5)
			res = 32'(op_q) - 32'd3;
		else if (op_q >= jvm_pkg::OP_ILOAD_0 && op_q <= jvm_pkg::OP_ILOAD_3)
			res = lv_q;
		else begin
			case (op_q)
				jvm_pkg::OP_BIPUSH: res = {{24{hi_q[7]}}, hi_q};
				jvm_pkg::OP_SIPUSH: res = {{16{hi_q[7]}}, off};
				jvm_pkg::OP_IADD:   res = a_q + b_q;
				jvm_pkg::OP_ISUB:   res = a_q - b_q;
				jvm_pkg::OP_IMUL:   res = mul_q;
				jvm_pkg::OP_IDIV:   res = dq;
				jvm_pkg::OP_IREM:   res = dr;
				jvm_pkg::OP_INEG:   res = 32'd0 - b_q;
				jvm_pkg::OP_DUP:    res = b_q;
				default: push_w = 1'b0;
			endcase
		end
	end
	// dup writes at sp, binary ops at sp-2, ineg at sp-1, pushes at sp
	assign wr_sp  = (op_q == jvm_pkg::OP_DUP) ? sp_q : (sp_q - jvm_pkg::SP_W'(npop));
	assign wr_idx = jvm_pkg::SA_W'(wr_sp);
	assign sp_new = jvm_pkg::SP_W'(sp_after);

	assign lv_rd = cmd.rd_b;
	assign lv_wr = cmd.commit && chk_q == jvm_pkg::ST_OK &&
		((op_q >= jvm_pkg::OP_ISTORE_0 && op_q <= jvm_pkg::OP_ISTORE_3) ||
		 (op_q == jvm_pkg::OP_IINC && 32'(hi_q) < 32'(jvm_pkg::LOCAL_COUNT)));
	assign lv_wdata = (op_q == jvm_pkg::OP_IINC) ? (lv_q + {{24{lo_q[7]}}, lo_q}) : b_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= func; hi_q <= operand_hi; lo_q <= operand_lo; pc_q <= insn_pc;
		end
		if (cmd.rd_b) begin
			b_q <= stk_mem[ra_b];
			a_q <= stk_mem[ra_a];
		end
		if (lv_rd) lv_q <= lv_mem[lv_idx];
		if (cmd.check) begin
			chk_q <= chk;
			mul_q <= a_q * b_q;
			// entry that becomes the top when nothing is pushed
			nt_q  <= stk_mem[jvm_pkg::SA_W'(sp_new - jvm_pkg::SP_W'(1))];
		end
		if (cmd.commit && chk_q == jvm_pkg::ST_OK && push_w)
			stk_mem[wr_idx] <= res;
		if (lv_wr) lv_mem[lv_idx] <= lv_wdata;
		if (cmd.commit) begin
			if (chk_q == jvm_pkg::ST_OK) begin
				next_pc      <= is_br ? (pc_q + off) : (pc_q + 16'(ilen));
				branch_taken <= is_br;
				if (sp_new == '0) top_q <= 32'd0;
				else if (push_w && wr_sp == sp_new - jvm_pkg::SP_W'(1)) top_q <= res;
				else if (push_w) top_q <= res;
				else top_q <= nt_q;
			end else begin
				next_pc      <= pc_q;
				branch_taken <= 1'b0;
				// stack untouched: top is the pre-read entry
				top_q        <= (sp_q == '0) ? 32'd0 : b_q;
			end
			status <= chk_q;
		end
	end

	// stack pointer, halt latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			halted_q <= 1'b0;
			hcode_q  <= jvm_pkg::ST_OK;
		end else if (cmd.commit) begin
			if (chk_q == jvm_pkg::ST_OK) sp_q <= sp_new;
			else if (!halted_q) begin
				halted_q <= 1'b1;
				hcode_q  <= chk_q;
			end
		end
	end

	// top when nothing written this step comes from the pre-read entries
	assign top_value   = top_q;
	assign stack_depth = 7'(sp_q);
endmodule

// ===== hw/rtl/jvm_ctrl.sv =====
// controller: sequences load, read, check, divide and commit
`timescale 1ns / 1ps
module jvm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output jvm_pkg::jvm_cmd_t cmd,
	input  jvm_pkg::jvm_sts_t sts
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd5;
	localparam logic [2:0] S_COMMIT = 3'd6;

	logic [2:0] state_q, state_d;
	logic       ov_q;

	// input is taken again once the previous word left the output register
	assign in_ready  = (state_q == S_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.load = 1'b1;
				state_d  = S_READ;
			end
			S_READ: begin
				cmd.rd_b = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.halt && sts.is_div) begin
					cmd.div_start = 1'b1;
					state_d = S_WAIT;
				end else state_d = S_COMMIT;
			end
			S_WAIT: if (sts.div_done) state_d = S_COMMIT;
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule

// ===== hw/rtl/jvm_int_bytecode_execute.sv =====
// top level of the integer bytecode execute unit
`timescale 1ns / 1ps
// steps from accepted word to result word: read, check, exec, commit; idiv and irem
// that do not halt run the bit-serial divider between exec and commit
// a new word is accepted only in idle and while the output holds no word or it is taken
// the result register frees as soon as the consumer takes the word
// reset clears stack pointer, halt latch and the code length register; stack and
// locals hold garbage until written
module jvm_int_bytecode_execute (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         func,
	input  logic [7:0]         operand_hi,
	input  logic [7:0]         operand_lo,
	input  logic [15:0]        insn_pc,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        next_pc,
	output logic               branch_taken,
	output logic [2:0]         status,
	output logic signed [31:0] top_value,
	output logic [6:0]         stack_depth
);
	jvm_pkg::jvm_cmd_t cmd;
	jvm_pkg::jvm_sts_t sts;
	logic [15:0] code_len_q;

	// code length register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) code_len_q <= '0;
		else if (cfg_valid) code_len_q <= cfg_data;
	end

	jvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	jvm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .operand_hi(operand_hi), .operand_lo(operand_lo),
		.insn_pc(insn_pc), .code_len(code_len_q),
		.next_pc(next_pc), .branch_taken(branch_taken), .status(status),
		.top_value(top_value), .stack_depth(stack_depth)
	);
endmodule
